[rtl/core/lz10d_pkg.sv]
package lz10d_pkg;

  // window geometry
  localparam int WindowBytes = 32'h1000;
  localparam int WinAddrBits = $clog2(WindowBytes);

  // declared size and output count widths
  localparam int CountBits = 24;
  localparam int SizeBits  = 24;
  localparam logic [CountBits-1:0] SizeMask = CountBits'((64'd1 << SizeBits) - 64'd1);

  // stream format constants
  localparam logic [7:0] MagicByte   = 8'h10;
  localparam logic [3:0] BitsPerFlag = 4'd8;
  localparam int         LenBits     = 5;
  localparam logic [LenBits-1:0] MinMatch = LenBits'(3);
  localparam logic [LenBits-1:0] MaxMatch = LenBits'(18);

  // stream parse phase
  typedef enum logic [2:0] {
    PhMagic = 3'd0,
    PhSize0 = 3'd1,
    PhSize1 = 3'd2,
    PhSize2 = 3'd3,
    PhData  = 3'd4,
    PhPair  = 3'd5,
    PhDone  = 3'd6,
    PhError = 3'd7
  } phase_e;

  // status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadMagic = 2'd1,
    StBadRef   = 2'd2
  } status_e;

  // control sequencer
  typedef enum logic {
    CtlIdle = 1'b0,
    CtlCopy = 1'b1
  } ctl_e;

endpackage

[rtl/core/lz10d_ram.sv]
module lz10d_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lz10_stream_decompressor_top.sv]
// a result is registered and shown in the cycle after its input transaction;
// the first byte of a back-reference follows the window read and is registered in turn
// magic, size, flag, literal, padding and error-state bytes each give one result
// the second byte of a back-reference starts one window read, then n copied bytes
// follow at one per cycle unless the output stalls (n = len 3..18, fewer when clipped)
// reset: rst_ni async clears all control state; the window ram is not cleared
module lz10_stream_decompressor_top
  import lz10d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_data_o,
  output logic       last_of_run_o,
  output logic       stream_done_o,
  output logic [1:0] status_o
);

  // stream state
  phase_e                 phase_q, phase_d;
  status_e                status_q, status_d;
  logic [WinAddrBits-1:0] wp_q, wp_d;
  logic [CountBits-1:0]   bytes_out_q, bytes_out_d;
  logic [CountBits-1:0]   declared_q, declared_d;
  logic [7:0]             flag_q, flag_d;
  logic [3:0]             bits_left_q, bits_left_d;
  logic [7:0]             pair_high_q, pair_high_d;

  // copy sequencer
  ctl_e                   ctl_q, ctl_d;
  logic [WinAddrBits-1:0] off_q, off_d;
  logic [LenBits-1:0]     left_q, left_d;
  logic                   fwd_hit_q, fwd_hit_d;
  logic [7:0]             fwd_data_q, fwd_data_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       has_data_q, last_q, done_q;
  status_e    out_status_q;

  // window ram ports
  logic                   ram_we, ram_re;
  logic [WinAddrBits-1:0] ram_wa, ram_ra;
  logic [7:0]             ram_wd, ram_rd;

  // result to load
  logic       load;
  logic [7:0] o_byte;
  logic       o_has, o_last;

  // state as seen by an accepted byte, after an optional stream start
  phase_e                 e_phase;
  status_e                e_status;
  logic [WinAddrBits-1:0] e_wp;
  logic [CountBits-1:0]   e_bytes, e_decl;
  logic [7:0]             e_flag, e_pair;
  logic [3:0]             e_bits;

  logic slot_free, in_acc;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && (ctl_q == CtlIdle) && slot_free;
  assign in_stall_o = !((ctl_q == CtlIdle) && slot_free);

  assign e_phase  = stream_start_i ? PhMagic : phase_q;
  assign e_status = stream_start_i ? StOk : status_q;
  assign e_wp     = stream_start_i ? '0 : wp_q;
  assign e_bytes  = stream_start_i ? '0 : bytes_out_q;
  assign e_decl   = stream_start_i ? '0 : declared_q;
  assign e_flag   = stream_start_i ? '0 : flag_q;
  assign e_pair   = stream_start_i ? '0 : pair_high_q;
  assign e_bits   = stream_start_i ? '0 : bits_left_q;

  lz10d_ram #(
    .Width (8),
    .Depth (WindowBytes)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  // next state: byte decode and back-reference copy
  always_comb begin
    logic [WinAddrBits-1:0] off_v;
    logic [CountBits-1:0]   size_v;
    logic [7:0]             byte_v;
    off_v  = '0;
    size_v = '0;
    byte_v = '0;

    phase_d     = phase_q;
    status_d    = status_q;
    wp_d        = wp_q;
    bytes_out_d = bytes_out_q;
    declared_d  = declared_q;
    flag_d      = flag_q;
    bits_left_d = bits_left_q;
    pair_high_d = pair_high_q;
    ctl_d       = ctl_q;
    off_d       = off_q;
    left_d      = left_q;
    fwd_hit_d   = fwd_hit_q;
    fwd_data_d  = fwd_data_q;

    ram_we = 1'b0;
    ram_wa = wp_q;
    ram_wd = '0;
    ram_re = 1'b0;
    ram_ra = '0;

    load   = 1'b0;
    o_byte = '0;
    o_has  = 1'b0;
    o_last = 1'b1;

    unique case (ctl_q)
      CtlIdle: begin
        if (in_acc) begin
          phase_d     = e_phase;
          status_d    = e_status;
          wp_d        = e_wp;
          bytes_out_d = e_bytes;
          declared_d  = e_decl;
          flag_d      = e_flag;
          bits_left_d = e_bits;
          pair_high_d = e_pair;
          load        = 1'b1;
          unique case (e_phase)
            PhMagic: begin
              if (in_byte_i == MagicByte) begin
                phase_d = PhSize0;
              end else begin
                status_d = StBadMagic;
                phase_d  = PhError;
              end
            end
            PhSize0: begin
              declared_d = {16'd0, in_byte_i};
              phase_d    = PhSize1;
            end
            PhSize1: begin
              declared_d = e_decl | {8'd0, in_byte_i, 8'd0};
              phase_d    = PhSize2;
            end
            PhSize2: begin
              size_v     = (e_decl | {in_byte_i, 16'd0}) & SizeMask;
              declared_d = size_v;
              phase_d    = (size_v == '0) ? PhDone : PhData;
            end
            PhData: begin
              if (e_bits == '0) begin
                flag_d      = in_byte_i;
                bits_left_d = BitsPerFlag;
              end else begin
                flag_d      = {e_flag[6:0], 1'b0};
                bits_left_d = e_bits - 4'd1;
                if (!e_flag[7]) begin
                  // literal
                  ram_we      = 1'b1;
                  ram_wa      = e_wp;
                  ram_wd      = in_byte_i;
                  wp_d        = e_wp + 1'b1;
                  bytes_out_d = e_bytes + 1'b1;
                  if (bytes_out_d >= e_decl) begin
                    phase_d = PhDone;
                  end
                  o_byte = in_byte_i;
                  o_has  = 1'b1;
                end else begin
                  pair_high_d = in_byte_i;
                  phase_d     = PhPair;
                end
              end
            end
            PhPair: begin
              off_v = {e_pair[3:0], in_byte_i};
              if ({{(CountBits-WinAddrBits){1'b0}}, off_v} >= e_bytes) begin
                status_d = StBadRef;
                phase_d  = PhError;
              end else begin
                // start copy: first window read now, results follow
                phase_d   = PhData;
                off_d     = off_v;
                left_d    = {1'b0, e_pair[7:4]} + MinMatch;
                ram_re    = 1'b1;
                ram_ra    = e_wp + ~off_v;
                fwd_hit_d = 1'b0;
                ctl_d     = CtlCopy;
                load      = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CtlCopy: begin
        if (slot_free) begin
          byte_v      = fwd_hit_q ? fwd_data_q : ram_rd;
          ram_we      = 1'b1;
          ram_wa      = wp_q;
          ram_wd      = byte_v;
          wp_d        = wp_q + 1'b1;
          bytes_out_d = bytes_out_q + 1'b1;
          left_d      = left_q - 1'b1;
          load        = 1'b1;
          o_byte      = byte_v;
          o_has       = 1'b1;
          o_last      = (left_q == LenBits'(1)) || (bytes_out_d >= declared_q);
          if (bytes_out_d >= declared_q) begin
            phase_d = PhDone;
          end
          if (o_last) begin
            ctl_d = CtlIdle;
          end else begin
            // next source byte, forwarded when it is the byte written now
            ram_re     = 1'b1;
            ram_ra     = wp_d + ~off_q;
            fwd_hit_d  = (ram_ra == ram_wa);
            fwd_data_d = byte_v;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      status_q    <= StOk;
      wp_q        <= '0;
      bytes_out_q <= '0;
      declared_q  <= '0;
      flag_q      <= '0;
      bits_left_q <= '0;
      pair_high_q <= '0;
      ctl_q       <= CtlIdle;
      left_q      <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      status_q    <= status_d;
      wp_q        <= wp_d;
      bytes_out_q <= bytes_out_d;
      declared_q  <= declared_d;
      flag_q      <= flag_d;
      bits_left_q <= bits_left_d;
      pair_high_q <= pair_high_d;
      ctl_q       <= ctl_d;
      left_q      <= left_d;
      fwd_hit_q   <= fwd_hit_d;
      if (slot_free) begin
        out_valid_q <= load;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    fwd_data_q <= fwd_data_d;
    if (load) begin
      out_byte_q   <= o_byte;
      has_data_q   <= o_has;
      last_q       <= o_last;
      done_q       <= (phase_d == PhDone);
      out_status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign has_data_o    = has_data_q;
  assign last_of_run_o = last_q;
  assign stream_done_o = done_q;
  assign status_o      = out_status_q;

  // copy runs only below the declared size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == CtlCopy) |-> (bytes_out_q < declared_q))
    else $error("copy active at or past declared size");

  // remaining copy length stays within match bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == CtlCopy) |-> ((left_q != '0) && (left_q <= MaxMatch)))
    else $error("copy length out of range");

  // error phase and nonzero status go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhError) |-> (status_q == StOk))
    else $error("status set outside error phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError) |-> (status_q != StOk))
    else $error("error phase without status");

  // a finished copy hands back to idle with data emitted on the last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctl_q == CtlCopy) && slot_free && (left_q == LenBits'(1))) |=>
      ((ctl_q == CtlIdle) && out_valid_q && has_data_q && last_q))
    else $error("copy did not close with a last data result");

endmodule
